>>> rtl/mip_pkg.sv
`default_nettype none
package mip_pkg;

    // field width of modulus, value and inverse
    localparam int MOD_BITS = 31;

    // step counter width, able to hold MOD_BITS itself
    localparam int CNT_W = $clog2(MOD_BITS + 1);

    // modulus after reset
    localparam logic [MOD_BITS-1:0] MODULUS_RESET = MOD_BITS'(64'd1000000007);

    // status of an iterative arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage
`default_nettype wire

>>> rtl/mip_intf.sv
`default_nettype none
// input item channel
interface mip_in_if;
    logic                          valid;
    logic                          ready;
    logic [mip_pkg::MOD_BITS-1:0]  value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// result item channel
interface mip_out_if;
    logic                          valid;
    logic                          ready;
    logic [mip_pkg::MOD_BITS-1:0]  inverse;
    logic                          no_inverse;

    modport source (output valid, output inverse, output no_inverse, input ready);
    modport sink   (input valid, input inverse, input no_inverse, output ready);
endinterface

// modulus register write channel
interface mip_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mip_pkg::MOD_BITS-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/mip_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle
module mip_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [mip_pkg::MOD_BITS-1:0]  i_dividend,
    input  wire logic [mip_pkg::MOD_BITS-1:0]  i_divisor,
    output mip_pkg::t_unit_sts                 o_sts,
    output logic [mip_pkg::MOD_BITS-1:0]       o_quot,
    output logic [mip_pkg::MOD_BITS-1:0]       o_rem
);

    logic                          r_busy;
    logic                          r_done;
    logic [mip_pkg::CNT_W-1:0]     r_cnt;
    logic [mip_pkg::MOD_BITS-1:0]  r_div;
    logic [mip_pkg::MOD_BITS-1:0]  r_rem;
    logic [mip_pkg::MOD_BITS-1:0]  r_sh;

    logic [mip_pkg::MOD_BITS:0]    trial;
    logic                          ge;
    logic [mip_pkg::MOD_BITS:0]    diff;

    // shift in next dividend bit and try to subtract
    always_comb begin
        trial = {r_rem, r_sh[mip_pkg::MOD_BITS-1]};
        ge    = trial >= {1'b0, r_div};
        diff  = trial - {1'b0, r_div};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= mip_pkg::CNT_W'(mip_pkg::MOD_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == mip_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= '0;
            r_sh  <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? diff[mip_pkg::MOD_BITS-1:0] : trial[mip_pkg::MOD_BITS-1:0];
            r_sh  <= {r_sh[mip_pkg::MOD_BITS-2:0], ge};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_sh;
    assign o_rem      = r_rem;

endmodule
`default_nettype wire

>>> rtl/mip_mulmod.sv
`default_nettype none
// modular multiplier, msb-first double and add, one multiplier bit per cycle
module mip_mulmod (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [mip_pkg::MOD_BITS-1:0]  i_x,
    input  wire logic [mip_pkg::MOD_BITS-1:0]  i_y,
    input  wire logic [mip_pkg::MOD_BITS-1:0]  i_mod,
    output mip_pkg::t_unit_sts                 o_sts,
    output logic [mip_pkg::MOD_BITS-1:0]       o_prod
);

    logic                          r_busy;
    logic                          r_done;
    logic [mip_pkg::CNT_W-1:0]     r_cnt;
    logic [mip_pkg::MOD_BITS-1:0]  r_x;
    logic [mip_pkg::MOD_BITS-1:0]  r_y;
    logic [mip_pkg::MOD_BITS-1:0]  r_mod;
    logic [mip_pkg::MOD_BITS-1:0]  r_acc;

    logic [mip_pkg::MOD_BITS:0]    dbl;
    logic [mip_pkg::MOD_BITS:0]    dbl_red;
    logic [mip_pkg::MOD_BITS:0]    sum;
    logic [mip_pkg::MOD_BITS:0]    sum_red;
    logic [mip_pkg::MOD_BITS:0]    mod_ext;

    // acc = 2*acc mod m, then add x mod m when the multiplier bit is set
    always_comb begin
        mod_ext = {1'b0, r_mod};
        dbl     = {r_acc, 1'b0};
        dbl_red = (dbl >= mod_ext) ? dbl - mod_ext : dbl;
        sum     = dbl_red + (r_y[mip_pkg::MOD_BITS-1] ? {1'b0, r_x} : '0);
        sum_red = (sum >= mod_ext) ? sum - mod_ext : sum;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= mip_pkg::CNT_W'(mip_pkg::MOD_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == mip_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_mod <= i_mod;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= sum_red[mip_pkg::MOD_BITS-1:0];
            r_y   <= {r_y[mip_pkg::MOD_BITS-2:0], 1'b0};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_prod     = r_acc;

endmodule
`default_nettype wire

>>> rtl/modular_inverse_prime.sv
// values that fail the range check or equal 1 go from the check state straight to
//   the result; all others first run R rounds, R = data-dependent number of rounds
// each round: a check, a divide (quotient and remainder), then a modular
//   multiply
// one item at a time, not ready while busy; result stalls add to the item time
// reset: synchronous active-low, modulus returns to 1000000007, no item in flight
`default_nettype none
module modular_inverse_prime (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mip_in_if.sink     i_in,
    mip_out_if.source  o_out,
    mip_cfg_if.sink    i_cfg
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]                    r_state;
    logic [2:0]                    n_state;
    logic [mip_pkg::MOD_BITS-1:0]  r_modulus;
    logic [mip_pkg::MOD_BITS-1:0]  r_m;
    logic [mip_pkg::MOD_BITS-1:0]  n_m;
    logic [mip_pkg::MOD_BITS-1:0]  r_a;
    logic [mip_pkg::MOD_BITS-1:0]  n_a;
    logic [mip_pkg::MOD_BITS-1:0]  r_b;
    logic [mip_pkg::MOD_BITS-1:0]  n_b;
    logic                          r_fail;
    logic                          n_fail;

    logic                          div_start;
    logic                          mul_start;
    mip_pkg::t_unit_sts            div_sts;
    mip_pkg::t_unit_sts            mul_sts;
    logic [mip_pkg::MOD_BITS-1:0]  quot;
    logic [mip_pkg::MOD_BITS-1:0]  rem;
    logic [mip_pkg::MOD_BITS-1:0]  prod;
    logic [mip_pkg::MOD_BITS-1:0]  half;
    logic                          in_acc;

    assign in_acc = i_in.valid && i_in.ready;
    assign half   = r_m >> 1;

    // modulus register
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= mip_pkg::MODULUS_RESET;
        end else if (i_cfg.valid) begin
            r_modulus <= i_cfg.data;
        end
    end

    // shared divider: m / b
    mip_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_m),
        .i_divisor  (r_b),
        .o_sts      (div_sts),
        .o_quot     (quot),
        .o_rem      (rem)
    );

    // shared modular multiplier: a * quotient mod m
    mip_mulmod u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_x     (r_a),
        .i_y     (quot),
        .i_mod   (r_m),
        .o_sts   (mul_sts),
        .o_prod  (prod)
    );

    // round sequencer
    always_comb begin
        n_state   = r_state;
        n_m       = r_m;
        n_a       = r_a;
        n_b       = r_b;
        n_fail    = r_fail;
        div_start = 1'b0;
        mul_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_m     = r_modulus;
                    n_a     = mip_pkg::MOD_BITS'(1);
                    n_b     = i_in.value;
                    n_fail  = (i_in.value == '0) || (i_in.value >= r_modulus);
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_fail || r_b == mip_pkg::MOD_BITS'(1)) begin
                    n_state = S_OUT;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_sts.done) begin
                    // b * (m / b) mod m is m minus the remainder, or 0
                    if (rem == '0) begin
                        n_fail  = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_b       = r_m - rem;
                        mul_start = 1'b1;
                        n_state   = S_MUL;
                    end
                end
            end
            S_MUL: begin
                if (mul_sts.done) begin
                    // negate both when b passes half the modulus
                    if (r_b > half) begin
                        n_a = (prod == '0) ? '0 : r_m - prod;
                        n_b = r_m - r_b;
                    end else begin
                        n_a = prod;
                    end
                    n_state = S_CHK;
                end
            end
            S_OUT: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_m    <= n_m;
        r_a    <= n_a;
        r_b    <= n_b;
        r_fail <= n_fail;
    end

    // ports
    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = (r_state == S_OUT);
    assign o_out.inverse    = r_fail ? '0 : r_a;
    assign o_out.no_inverse = r_fail;

    // checks
    a_ready_not_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid)
        else $error("input ready while a result is pending");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_b != '0))
        else $error("divider running on a zero divisor");

    a_a_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_a < r_m))
        else $error("a not reduced below the modulus");

    a_unit_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state != S_DIV) || div_sts.busy || div_sts.done) &&
        ((r_state != S_MUL) || mul_sts.busy || mul_sts.done))
        else $error("waiting on an idle arithmetic unit");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.no_inverse) |-> (o_out.inverse == '0))
        else $error("nonzero inverse flagged as failed");

endmodule
`default_nettype wire
